// ===== hdl/mgas_pkg.sv =====
// ----------------------------------------------------------------------------
// mgas_pkg
// Shared widths, reset constants and types for the median-gated aim setpoint.
// ----------------------------------------------------------------------------
package mgas_pkg;

    localparam int YAW_W         = 20;
    localparam int LIMIT_W       = 19;
    localparam int RING_DEPTH_DF = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

    typedef struct packed {
        logic busy;
        logic done;
    } t_rank_stat;

endpackage

// ===== hdl/mgas_ring_mem.sv =====
// ----------------------------------------------------------------------------
// mgas_ring_mem
// Yaw ring storage: one write port, two registered read ports. Per-entry
// valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module mgas_ring_mem
    import mgas_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DF,
    parameter int IW         = $clog2(RING_DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_we,
    input  logic [IW-1:0]           i_waddr,
    input  logic signed [YAW_W-1:0] i_wdata,
    input  logic                    i_re,
    input  logic [IW-1:0]           i_raddr_a,
    input  logic [IW-1:0]           i_raddr_b,
    output logic signed [YAW_W-1:0] o_rdata_a,
    output logic signed [YAW_W-1:0] o_rdata_b
);

    logic signed [YAW_W-1:0] r_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0]   r_vld;
    logic signed [YAW_W-1:0] r_rd_a;
    logic signed [YAW_W-1:0] r_rd_b;
    logic                    r_va;
    logic                    r_vb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_a <= r_mem[i_raddr_a];
            r_rd_b <= r_mem[i_raddr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_va <= r_vld[i_raddr_a];
                r_vb <= r_vld[i_raddr_b];
            end
        end
    end

    assign o_rdata_a = r_va ? r_rd_a : '0;
    assign o_rdata_b = r_vb ? r_rd_b : '0;

endmodule

// ===== hdl/mgas_rank.sv =====
// ----------------------------------------------------------------------------
// mgas_rank
// Rank-counting median search: sweeps every (candidate, other) pair through
// the ring memory and keeps the candidate whose rank covers the middle index.
// ----------------------------------------------------------------------------
module mgas_rank
    import mgas_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DF,
    parameter int IW         = $clog2(RING_DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_re,
    output logic [IW-1:0]           o_raddr_a,
    output logic [IW-1:0]           o_raddr_b,
    input  logic signed [YAW_W-1:0] i_rdata_a,
    input  logic signed [YAW_W-1:0] i_rdata_b,
    output logic signed [YAW_W-1:0] o_median,
    output t_rank_stat              o_stat
);

    localparam int CW  = $clog2(RING_DEPTH + 1);
    localparam int MID = RING_DEPTH / 2;
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

    logic [IW-1:0]           r_i;
    logic [IW-1:0]           r_j;
    logic                    r_run;
    logic                    r_dv;
    logic                    r_dlast;
    logic                    r_dfinal;
    logic                    r_done;
    logic [CW-1:0]           r_cnt_lt;
    logic [CW-1:0]           r_cnt_le;
    logic signed [YAW_W-1:0] r_med;

    logic [CW-1:0] n_lt;
    logic [CW-1:0] n_le;
    logic          is_med;

    always_comb begin
        n_lt   = r_cnt_lt + CW'(i_rdata_b <  i_rdata_a);
        n_le   = r_cnt_le + CW'(i_rdata_b <= i_rdata_a);
        is_med = (n_lt <= CW'(MID)) && (n_le > CW'(MID));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i      <= '0;
            r_j      <= '0;
            r_run    <= 1'b0;
            r_dv     <= 1'b0;
            r_dlast  <= 1'b0;
            r_dfinal <= 1'b0;
            r_done   <= 1'b0;
            r_cnt_lt <= '0;
            r_cnt_le <= '0;
        end else begin
            r_dv     <= r_run;
            r_dlast  <= r_run && (r_j == LAST_IDX);
            r_dfinal <= r_run && (r_j == LAST_IDX) && (r_i == LAST_IDX);
            r_done   <= r_dv && r_dfinal;

            if (i_start) begin
                r_i   <= '0;
                r_j   <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                if (r_j == LAST_IDX) begin
                    r_j <= '0;
                    if (r_i == LAST_IDX) begin
                        r_run <= 1'b0;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end

            if (r_dv) begin
                if (r_dlast) begin
                    r_cnt_lt <= '0;
                    r_cnt_le <= '0;
                end else begin
                    r_cnt_lt <= n_lt;
                    r_cnt_le <= n_le;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_dv && r_dlast && is_med) begin
            r_med <= i_rdata_a;
        end
    end

    assign o_re        = r_run;
    assign o_raddr_a   = r_i;
    assign o_raddr_b   = r_j;
    assign o_median    = r_med;
    assign o_stat.busy = r_run | r_dv | r_done;
    assign o_stat.done = r_done;

endmodule

// ===== hdl/median_gated_aim_setpoint.sv =====
// ----------------------------------------------------------------------------
// median_gated_aim_setpoint
// Turret setpoint from measured position plus the median of recent yaws,
// clamped to a programmable magnitude.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (i_valid/o_ready) carry a target-valid flag, a yaw and
//   the current position. A valid yaw is stored in the ring at the write
//   slot; the slot advances on every request.
//   Output requests (o_valid/i_ready) carry the clamped setpoint, one per
//   input request, in order.
//   Limit is written through i_cfg_we/i_cfg_wdata; the user must write it
//   only while idle, as the block itself does not enforce this.
//   The setpoint waits on the pairwise rank sweep, which reads one pair
//   of ring entries per cycle; no new request is taken until the current
//   result is loaded into the output register, and o_ready returns the
//   cycle after the result is loaded.
//   A stalled output register does not block input: the next request is
//   taken and ranked; only its result waits for the register to free.
//   Reset: ring reads as zero, slot zero, limit at full scale; no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module median_gated_aim_setpoint
    import mgas_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_target_valid,
    input  logic signed [YAW_W-1:0]   i_target_yaw,
    input  logic signed [YAW_W-1:0]   i_current_position,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [YAW_W-1:0]   o_new_setpoint,
    input  logic                      i_cfg_we,
    input  logic [LIMIT_W-1:0]        i_cfg_wdata
);

    localparam int IW = $clog2(RING_DEPTH);
    localparam int SW = YAW_W + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_RANK,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic [IW-1:0]           r_slot;
    logic [LIMIT_W-1:0]      r_limit;
    logic signed [YAW_W-1:0] r_pos;
    logic                    r_out_valid;
    logic signed [YAW_W-1:0] r_out;

    logic                    in_acc;
    logic                    out_free;
    logic                    emit;
    logic                    mem_re;
    logic [IW-1:0]           raddr_a;
    logic [IW-1:0]           raddr_b;
    logic signed [YAW_W-1:0] rdata_a;
    logic signed [YAW_W-1:0] rdata_b;
    logic signed [YAW_W-1:0] median;
    t_rank_stat              rank_stat;
    logic signed [SW-1:0]    sum;
    logic signed [SW-1:0]    lim_p;
    logic signed [SW-1:0]    lim_n;
    logic signed [YAW_W-1:0] n_out;

    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign emit     = ((r_state == S_RANK && rank_stat.done) || r_state == S_EMIT)
                      && out_free;

    mgas_ring_mem #(
        .RING_DEPTH (RING_DEPTH),
        .IW         (IW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (in_acc && i_target_valid),
        .i_waddr    (r_slot),
        .i_wdata    (i_target_yaw),
        .i_re       (mem_re),
        .i_raddr_a  (raddr_a),
        .i_raddr_b  (raddr_b),
        .o_rdata_a  (rdata_a),
        .o_rdata_b  (rdata_b)
    );

    mgas_rank #(
        .RING_DEPTH (RING_DEPTH),
        .IW         (IW)
    ) u_rank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .o_re       (mem_re),
        .o_raddr_a  (raddr_a),
        .o_raddr_b  (raddr_b),
        .i_rdata_a  (rdata_a),
        .i_rdata_b  (rdata_b),
        .o_median   (median),
        .o_stat     (rank_stat)
    );

    // clamp to +/- limit
    always_comb begin
        sum   = SW'(r_pos) + SW'(median);
        lim_p = SW'({1'b0, r_limit});
        lim_n = -lim_p;
        if (sum > lim_p) begin
            n_out = YAW_W'(lim_p);
        end else if (sum < lim_n) begin
            n_out = YAW_W'(lim_n);
        end else begin
            n_out = YAW_W'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pos <= i_current_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_slot  <= (r_slot == LAST_IDX) ? '0 : r_slot + 1'b1;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_state <= S_RANK;
                end
                S_RANK, S_EMIT: begin
                    if (emit) begin
                        r_out   <= n_out;
                        r_state <= S_IDLE;
                    end else if (rank_stat.done) begin
                        r_state <= S_EMIT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_new_setpoint = r_out;

`ifndef SYNTHESIS
    a_ready_rank_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !rank_stat.busy)
        else $error("input taken while rank sweep active");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= LAST_IDX)
        else $error("write slot out of range");

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second request taken before ranking");

    a_done_in_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rank_stat.done |-> (r_state == S_RANK))
        else $error("rank result outside rank state");
`endif

endmodule
